// File: hdl/scx_pkg.sv
package scx_pkg;

    // One input word as it travels through the front queue
    typedef struct packed {
        logic [7:0] data_byte;
        logic       begin_req;
        logic       last;
    } scx_item_t;

    // Keystream word write from the block engine into the keystream buffer
    typedef struct packed {
        logic        valid;
        logic [3:0]  addr;
        logic [31:0] data;
        logic        done;
    } scx_ks_wr_t;

    localparam int STATE_WORDS   = 16;
    localparam int DOUBLE_ROUNDS = 10;
    localparam int HALF_ROUNDS   = 2 * DOUBLE_ROUNDS;
    localparam int LANES         = 4;

    localparam int ROT_A = 16;
    localparam int ROT_B = 12;
    localparam int ROT_C = 8;
    localparam int ROT_D = 7;

    localparam logic [31:0] SIGMA_0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA_1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA_2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA_3 = 32'h6b20_6574;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_0      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_1      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_2      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_3      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HIGH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_INIT_CTR   = 3'd6;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

// File: hdl/stream_cipher_keystream_xor.sv
// ChaCha20 (RFC 7539) keystream XOR, one byte per word. Push bytes in with
// begin_req set on the first byte of a message to load the block counter
// from initial_counter; each result is the byte XORed with the next
// keystream byte, with last passed through. Words queue in a FIFO_DEPTH
// input queue, so the source keeps pushing while the back end works. A byte
// that finds keystream in the 64-byte buffer passes through the back end in
// order: take, buffer read, output. A byte that opens a new block (first
// byte, begin_req, or every 64th byte) first starts the block engine:
// rounds in the quarter-round unit (four lanes, one add/xor/rotate step per
// cycle, 20 half rounds of 4 steps), then the input state is added back
// and the buffer is written one word per cycle; buffer read and output
// follow. Write the key, nonce and counter registers only while the block
// is idle; the key and nonce are read when a block is started and again
// while the input state is added back.
module stream_cipher_keystream_xor
    import scx_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [7:0]             data_byte,
    input  logic                   begin_req,
    input  logic                   last,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             out_byte,
    output logic                   out_last,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [63:0]       key_0_reg, key_1_reg, key_2_reg, key_3_reg;
    logic [63:0]       nonce_low_reg;
    logic [31:0]       nonce_high_reg;
    logic [31:0]       init_ctr_reg;
    logic [7:0][31:0]  key_words;
    logic [2:0][31:0]  nonce_words;
    scx_item_t         item_in;
    scx_item_t         head;
    logic              q_empty;
    logic              q_pop;
    logic              core_start;
    logic [31:0]       counter;
    scx_ks_wr_t        ks_wr;

    // Configuration registers; unknown indexes drop the write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_0_reg      <= '0;
            key_1_reg      <= '0;
            key_2_reg      <= '0;
            key_3_reg      <= '0;
            nonce_low_reg  <= '0;
            nonce_high_reg <= '0;
            init_ctr_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_KEY_0:      key_0_reg      <= cfg_data;
                REG_KEY_1:      key_1_reg      <= cfg_data;
                REG_KEY_2:      key_2_reg      <= cfg_data;
                REG_KEY_3:      key_3_reg      <= cfg_data;
                REG_NONCE_LOW:  nonce_low_reg  <= cfg_data;
                REG_NONCE_HIGH: nonce_high_reg <= cfg_data[31:0];
                REG_INIT_CTR:   init_ctr_reg   <= cfg_data[31:0];
                default:        ;
            endcase
        end
    end

    // Split the 64-bit registers into little-endian state words
    assign key_words[0]   = key_0_reg[31:0];
    assign key_words[1]   = key_0_reg[63:32];
    assign key_words[2]   = key_1_reg[31:0];
    assign key_words[3]   = key_1_reg[63:32];
    assign key_words[4]   = key_2_reg[31:0];
    assign key_words[5]   = key_2_reg[63:32];
    assign key_words[6]   = key_3_reg[31:0];
    assign key_words[7]   = key_3_reg[63:32];
    assign nonce_words[0] = nonce_low_reg[31:0];
    assign nonce_words[1] = nonce_low_reg[63:32];
    assign nonce_words[2] = nonce_high_reg;

    assign item_in.data_byte = data_byte;
    assign item_in.begin_req = begin_req;
    assign item_in.last      = last;

    scx_front #(
        .DEPTH (FIFO_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item_in (item_in),
        .pop     (q_pop),
        .empty   (q_empty),
        .head    (head)
    );

    scx_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (core_start),
        .key_words   (key_words),
        .nonce_words (nonce_words),
        .counter     (counter),
        .ks_wr       (ks_wr)
    );

    scx_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .q_empty         (q_empty),
        .q_pop           (q_pop),
        .initial_counter (init_ctr_reg),
        .ks_wr           (ks_wr),
        .core_start      (core_start),
        .counter         (counter),
        .out_byte        (out_byte),
        .out_last        (out_last),
        .empty           (empty),
        .pop             (pop)
    );

endmodule

// File: hdl/scx_front.sv
module scx_front
    import scx_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  scx_item_t item_in,
    input  logic      pop,
    output logic      empty,
    output scx_item_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scx_item_t          slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: hdl/scx_core.sv
module scx_core
    import scx_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [7:0][31:0] key_words,
    input  logic [2:0][31:0] nonce_words,
    input  logic [31:0]      counter,
    output scx_ks_wr_t       ks_wr
);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_ADD   = 3'b100
    } core_state_t;

    core_state_t                   state_reg, state_next;
    logic [STATE_WORDS-1:0][31:0]  init_w;
    logic [STATE_WORDS-1:0][31:0]  w_reg;
    logic [STATE_WORDS-1:0][31:0]  w_step;
    logic [4:0]                    rnd_reg, rnd_next;
    logic [1:0]                    step_reg, step_next;
    logic [3:0]                    idx_reg, idx_next;

    always_comb
    begin
        init_w[0]  = SIGMA_0;
        init_w[1]  = SIGMA_1;
        init_w[2]  = SIGMA_2;
        init_w[3]  = SIGMA_3;
        for (int i = 0; i < 8; i++)
        begin
            init_w[4 + i] = key_words[i];
        end
        init_w[12] = counter;
        init_w[13] = nonce_words[0];
        init_w[14] = nonce_words[1];
        init_w[15] = nonce_words[2];
    end

    // Four quarter-round lanes, one add/xor/rotate step each per cycle;
    // odd half rounds work on the diagonals
    always_comb
    begin
        logic [3:0]  ia, ib, ic, id;
        logic [31:0] a, b, c, d, s;
        logic        diag;
        w_step = w_reg;
        diag   = rnd_reg[0];
        for (int j = 0; j < LANES; j++)
        begin
            ia = 4'(j);
            ib = diag ? 4'(4 + ((j + 1) % LANES))  : 4'(4 + j);
            ic = diag ? 4'(8 + ((j + 2) % LANES))  : 4'(8 + j);
            id = diag ? 4'(12 + ((j + 3) % LANES)) : 4'(12 + j);
            a  = w_reg[ia];
            b  = w_reg[ib];
            c  = w_reg[ic];
            d  = w_reg[id];
            case (step_reg)
                2'd0:
                begin
                    s          = a + b;
                    w_step[ia] = s;
                    w_step[id] = rotl32(d ^ s, ROT_A);
                end
                2'd1:
                begin
                    s          = c + d;
                    w_step[ic] = s;
                    w_step[ib] = rotl32(b ^ s, ROT_B);
                end
                2'd2:
                begin
                    s          = a + b;
                    w_step[ia] = s;
                    w_step[id] = rotl32(d ^ s, ROT_C);
                end
                default:
                begin
                    s          = c + d;
                    w_step[ic] = s;
                    w_step[ib] = rotl32(b ^ s, ROT_D);
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    rnd_next   = '0;
                    step_next  = '0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    rnd_next = rnd_reg + 1'b1;
                    if (rnd_reg == 5'(HALF_ROUNDS - 1))
                    begin
                        idx_next   = '0;
                        state_next = C_ADD;
                    end
                end
            end
            C_ADD:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == 4'(STATE_WORDS - 1))
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            step_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == C_IDLE && start)
        begin
            w_reg <= init_w;
        end
        else if (state_reg == C_ROUND)
        begin
            w_reg <= w_step;
        end
    end

    // Add the input state back, one word per cycle
    assign ks_wr.valid = (state_reg == C_ADD);
    assign ks_wr.addr  = idx_reg;
    assign ks_wr.data  = w_reg[idx_reg] + init_w[idx_reg];
    assign ks_wr.done  = (state_reg == C_ADD) && (idx_reg == 4'(STATE_WORDS - 1));

endmodule

// File: hdl/scx_back.sv
module scx_back
    import scx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  scx_item_t   head,
    input  logic        q_empty,
    output logic        q_pop,
    input  logic [31:0] initial_counter,
    input  scx_ks_wr_t  ks_wr,
    output logic        core_start,
    output logic [31:0] counter,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        empty,
    input  logic        pop
);

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_LAUNCH = 5'b00010,
        B_GEN    = 5'b00100,
        B_READ   = 5'b01000,
        B_EMIT   = 5'b10000
    } back_state_t;

    back_state_t  state_reg, state_next;
    logic [31:0]  cnt_reg, cnt_next;
    logic [6:0]   pos_reg, pos_next;
    logic         out_valid_reg, out_valid_next;
    logic [7:0]   data_reg;
    logic         last_reg;
    logic [31:0]  word_reg;
    logic [1:0]   sel_reg;
    logic [7:0]   out_byte_reg;
    logic         out_last_reg;
    logic [31:0]  ks_mem [STATE_WORDS];
    logic         out_take;
    logic         rd_en;
    logic         emit;

    assign q_pop      = (state_reg == B_IDLE) && !q_empty;
    assign core_start = (state_reg == B_LAUNCH);
    assign rd_en      = (state_reg == B_READ);
    assign out_take   = !out_valid_reg || pop;
    assign emit       = (state_reg == B_EMIT) && out_take;
    assign counter    = cnt_reg;
    assign out_byte   = out_byte_reg;
    assign out_last   = out_last_reg;
    assign empty      = !out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.begin_req)
                    begin
                        cnt_next = initial_counter;
                    end
                    state_next = (head.begin_req || pos_reg[6]) ? B_LAUNCH : B_READ;
                end
            end
            B_LAUNCH:
            begin
                pos_next   = '0;
                state_next = B_GEN;
            end
            B_GEN:
            begin
                if (ks_wr.done)
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                pos_next   = pos_reg + 1'b1;
                state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            pos_reg       <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ks_wr.valid)
        begin
            ks_mem[ks_wr.addr] <= ks_wr.data;
        end
        if (rd_en)
        begin
            word_reg <= ks_mem[pos_reg[5:2]];
            sel_reg  <= pos_reg[1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            data_reg <= head.data_byte;
            last_reg <= head.last;
        end
        if (emit)
        begin
            out_byte_reg <= data_reg ^ word_reg[8 * sel_reg +: 8];
            out_last_reg <= last_reg;
        end
    end

endmodule

// File: hdl/scx_checker.sv
module scx_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic       pop,
    input logic       empty,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic [7:0] pending_reg, pending_next;

    // Count words taken in but not yet handed out
    always_comb
    begin
        pending_next = pending_reg;
        if ((push && !full) && !(pop && !empty))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // Hold a waiting result until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
        else $error("result changed while waiting");

    // Never show a result that no accepted word accounts for
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != 8'd0))
        else $error("result without a pending input word");

    // Back-pressure only while work is outstanding
    a_full_pending: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (pending_reg != 8'd0))
        else $error("full with nothing pending");

endmodule

bind stream_cipher_keystream_xor scx_checker u_scx_checker (.*);
